### src/lir_pkg.sv
// Shared types, constants and the control program of the linear-interpolation resampler.
// No dependencies; the resampler top level and its checker use it by scoped names.
`timescale 1ns / 1ps

package lir_pkg;

    localparam int FRAC_W = 24;
    localparam int POS_W = FRAC_W + 2;
    localparam int SRC_W = 22;
    localparam int DIV_W = SRC_W + FRAC_W;
    localparam int DEN_W = 27;
    localparam int CNT_W = $clog2(DIV_W);
    localparam int PROD_W = FRAC_W + 10;
    localparam int ABS_W = FRAC_W + 8;
    localparam int AMP_SHIFT = 15;
    localparam int SCL_W = ABS_W + AMP_SHIFT;
    localparam int OUT_SHIFT = FRAC_W + 7;
    localparam int PERIOD_W = 11;
    localparam int ADDR_W = 3;

    localparam int SRC_CLOCK = 3546895;
    localparam logic [15:0] OUT_RATE = 16'd48000;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 11'd428;
    localparam logic [DIV_W-1:0] DIV_NUM = DIV_W'(SRC_CLOCK) << FRAC_W;
    localparam logic [POS_W-1:0] PHASE_ONE = POS_W'(1) << FRAC_W;
    localparam logic REG_IDX_PERIOD = 1'b0;

    typedef struct packed {
        logic signed [7:0] sample_in;
        logic              last_in;
    } lir_in_t;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               last_out;
    } lir_out_t;

    typedef enum logic [3:0] {
        OP_FETCH,
        OP_DEN,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_STEP_SET,
        OP_FIRST,
        OP_NOP,
        OP_MUL_SPAN,
        OP_MUL_TAIL,
        OP_ABS,
        OP_EMIT,
        OP_WRAP,
        OP_FLUSH,
        OP_TAIL_TEST,
        OP_FINISH
    } lir_op_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_HAVE_PREV,
        C_DIV_MORE,
        C_LAST,
        C_POS_WRAP,
        C_TAIL_END
    } lir_cond_t;

    typedef logic [4:0] lir_upc_t;

    typedef struct packed {
        lir_op_t   op;
        lir_cond_t cond;
        lir_upc_t  target;
    } lir_uword_t;

    localparam lir_upc_t U_FETCH     = 5'd0;
    localparam lir_upc_t U_DEN       = 5'd1;
    localparam lir_upc_t U_DIV_INIT  = 5'd2;
    localparam lir_upc_t U_DIV_STEP  = 5'd3;
    localparam lir_upc_t U_STEP_SET  = 5'd4;
    localparam lir_upc_t U_FIRST     = 5'd5;
    localparam lir_upc_t U_SPAN_TEST = 5'd6;
    localparam lir_upc_t U_SPAN_MUL  = 5'd7;
    localparam lir_upc_t U_SPAN_ABS  = 5'd8;
    localparam lir_upc_t U_SPAN_EMIT = 5'd9;
    localparam lir_upc_t U_WRAP      = 5'd10;
    localparam lir_upc_t U_FLUSH     = 5'd11;
    localparam lir_upc_t U_TAIL_TEST = 5'd12;
    localparam lir_upc_t U_TAIL_MUL  = 5'd13;
    localparam lir_upc_t U_TAIL_ABS  = 5'd14;
    localparam lir_upc_t U_TAIL_EMIT = 5'd15;
    localparam lir_upc_t U_FINISH    = 5'd16;

    function automatic lir_uword_t lir_ucode(input lir_upc_t addr);
        lir_uword_t w;
        case (addr)
            U_FETCH:     w = '{OP_FETCH,     C_HAVE_PREV, U_SPAN_TEST};
            U_DEN:       w = '{OP_DEN,       C_NEXT,      U_FETCH};
            U_DIV_INIT:  w = '{OP_DIV_INIT,  C_NEXT,      U_FETCH};
            U_DIV_STEP:  w = '{OP_DIV_STEP,  C_DIV_MORE,  U_DIV_STEP};
            U_STEP_SET:  w = '{OP_STEP_SET,  C_LAST,      U_TAIL_TEST};
            U_FIRST:     w = '{OP_FIRST,     C_ALWAYS,    U_FETCH};
            U_SPAN_TEST: w = '{OP_NOP,       C_POS_WRAP,  U_WRAP};
            U_SPAN_MUL:  w = '{OP_MUL_SPAN,  C_NEXT,      U_FETCH};
            U_SPAN_ABS:  w = '{OP_ABS,       C_NEXT,      U_FETCH};
            U_SPAN_EMIT: w = '{OP_EMIT,      C_ALWAYS,    U_SPAN_TEST};
            U_WRAP:      w = '{OP_WRAP,      C_LAST,      U_TAIL_TEST};
            U_FLUSH:     w = '{OP_FLUSH,     C_ALWAYS,    U_FETCH};
            U_TAIL_TEST: w = '{OP_TAIL_TEST, C_TAIL_END,  U_FINISH};
            U_TAIL_MUL:  w = '{OP_MUL_TAIL,  C_NEXT,      U_FETCH};
            U_TAIL_ABS:  w = '{OP_ABS,       C_NEXT,      U_FETCH};
            U_TAIL_EMIT: w = '{OP_EMIT,      C_ALWAYS,    U_TAIL_TEST};
            U_FINISH:    w = '{OP_FINISH,    C_ALWAYS,    U_FETCH};
            default:     w = '{OP_NOP,       C_ALWAYS,    U_FETCH};
        endcase
        return w;
    endfunction

endpackage

### src/linear_interp_audio_resampler.sv
// Top level of the linear-interpolation audio resampler: APB register, sequencer and datapath.
// Depends on lir_pkg for payload types, constants and the control program.
`timescale 1ns / 1ps

// Converts signed 8-bit samples at 3546895/source_period Hz into a 48 kHz signed 16-bit
// stream by linear interpolation. A small control program steps one shared datapath: for
// the first sample of a clip a bit-serial divider derives the phase step from source_period
// (one quotient bit per cycle, 46 bits), and every result passes four steps (test,
// multiply, magnitude, scale). The final sample of a clip adds the tail results and marks
// the last one with last_out. Results pass through an output register, so a new input is
// taken while a result still waits. source_period is latched at the first sample of each
// clip and reads back at byte address 0.
module linear_interp_audio_resampler (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lir_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  lir_pkg::lir_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output lir_pkg::lir_out_t             m_data
);

    logic [lir_pkg::PERIOD_W-1:0]    period_reg, period_next;
    lir_pkg::lir_upc_t               upc_reg, upc_next;
    logic                            have_prev_reg, have_prev_next;
    logic [lir_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic [lir_pkg::FRAC_W-1:0]      step_reg, step_next;
    logic signed [7:0]               prev_reg, prev_next;
    logic signed [7:0]               cur_reg, cur_next;
    logic                            last_reg, last_next;
    logic [lir_pkg::DEN_W-1:0]       den_reg, den_next;
    logic [lir_pkg::DIV_W-1:0]       dq_reg, dq_next;
    logic [lir_pkg::DEN_W-1:0]       rem_reg, rem_next;
    logic [lir_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic signed [lir_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [7:0]               s1_reg, s1_next;
    logic [lir_pkg::ABS_W-1:0]       abs_reg, abs_next;
    logic                            neg_reg, neg_next;
    logic [15:0]                     pend_reg, pend_next;
    logic                            pend_valid_reg, pend_valid_next;
    logic                            m_valid_reg, m_valid_next;
    lir_pkg::lir_out_t               m_data_reg, m_data_next;

    lir_pkg::lir_uword_t             uw;
    logic                            stall;
    logic                            cond_true;
    logic                            out_free;
    logic                            push;
    logic                            push_last;
    logic                            cfg_write;
    logic [lir_pkg::DEN_W:0]         div_sh;
    logic                            div_bit;
    logic signed [lir_pkg::FRAC_W:0] frac_s;
    logic signed [8:0]               diff;
    logic signed [lir_pkg::PROD_W-1:0] span_v;
    logic [lir_pkg::SCL_W-1:0]       scaled;
    logic [15:0]                     mag;
    logic [15:0]                     result;
    logic [lir_pkg::POS_W-1:0]       pos_adv;

    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == lir_pkg::REG_IDX_PERIOD) ? 32'(period_reg) : 32'd0;
    assign s_ready = (uw.op == lir_pkg::OP_FETCH);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == lir_pkg::REG_IDX_PERIOD);

    always_comb begin
        uw        = lir_pkg::lir_ucode(upc_reg);
        out_free  = !m_valid_reg || m_ready;
        pos_adv   = lir_pkg::POS_W'(pos_reg + lir_pkg::POS_W'(step_reg));

        div_sh    = {rem_reg, dq_reg[lir_pkg::DIV_W-1]};
        div_bit   = (div_sh >= {1'b0, den_reg});

        frac_s    = $signed({1'b0, pos_reg[lir_pkg::FRAC_W-1:0]});
        diff      = 9'(cur_reg) - 9'(prev_reg);
        span_v    = (lir_pkg::PROD_W'(s1_reg) <<< lir_pkg::FRAC_W) + prod_reg;
        scaled    = {abs_reg, lir_pkg::AMP_SHIFT'(0)} - lir_pkg::SCL_W'(abs_reg);
        mag       = 16'(scaled >> lir_pkg::OUT_SHIFT);
        result    = neg_reg ? 16'(16'd0 - mag) : mag;

        stall = 1'b0;
        case (uw.op)
            lir_pkg::OP_FETCH: begin
                stall = !s_valid;
            end
            lir_pkg::OP_EMIT, lir_pkg::OP_FLUSH, lir_pkg::OP_FINISH: begin
                stall = pend_valid_reg && !out_free;
            end
            default: begin
                stall = 1'b0;
            end
        endcase

        case (uw.cond)
            lir_pkg::C_NEXT:      cond_true = 1'b0;
            lir_pkg::C_ALWAYS:    cond_true = 1'b1;
            lir_pkg::C_HAVE_PREV: cond_true = have_prev_reg;
            lir_pkg::C_DIV_MORE:  cond_true = (cnt_reg != lir_pkg::CNT_W'(lir_pkg::DIV_W - 1));
            lir_pkg::C_LAST:      cond_true = last_reg;
            lir_pkg::C_POS_WRAP:  cond_true = (pos_reg[lir_pkg::POS_W-1:lir_pkg::FRAC_W] != 2'b00);
            lir_pkg::C_TAIL_END:  cond_true = (pos_adv > lir_pkg::PHASE_ONE);
            default:              cond_true = 1'b0;
        endcase

        if (stall) begin
            upc_next = upc_reg;
        end else if (cond_true) begin
            upc_next = uw.target;
        end else begin
            upc_next = lir_pkg::lir_upc_t'(upc_reg + 5'd1);
        end

        period_next     = cfg_write ? pwdata[lir_pkg::PERIOD_W-1:0] : period_reg;
        have_prev_next  = have_prev_reg;
        pos_next        = pos_reg;
        step_next       = step_reg;
        prev_next       = prev_reg;
        cur_next        = cur_reg;
        last_next       = last_reg;
        den_next        = den_reg;
        dq_next         = dq_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        prod_next       = prod_reg;
        s1_next         = s1_reg;
        abs_next        = abs_reg;
        neg_next        = neg_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        push            = 1'b0;
        push_last       = 1'b0;

        if (!stall) begin
            case (uw.op)
                lir_pkg::OP_FETCH: begin
                    cur_next  = s_data.sample_in;
                    last_next = s_data.last_in;
                end
                lir_pkg::OP_DEN: begin
                    den_next = lir_pkg::DEN_W'(lir_pkg::OUT_RATE * period_reg);
                    pos_next = '0;
                end
                lir_pkg::OP_DIV_INIT: begin
                    dq_next  = lir_pkg::DIV_NUM + lir_pkg::DIV_W'(den_reg >> 1);
                    rem_next = '0;
                    cnt_next = '0;
                end
                lir_pkg::OP_DIV_STEP: begin
                    rem_next = div_bit ? lir_pkg::DEN_W'(div_sh - {1'b0, den_reg})
                                       : div_sh[lir_pkg::DEN_W-1:0];
                    dq_next  = {dq_reg[lir_pkg::DIV_W-2:0], div_bit};
                    cnt_next = lir_pkg::CNT_W'(cnt_reg + 1'b1);
                end
                lir_pkg::OP_STEP_SET: begin
                    if (|dq_reg[lir_pkg::DIV_W-1:lir_pkg::FRAC_W]) begin
                        step_next = '1;
                    end else begin
                        step_next = dq_reg[lir_pkg::FRAC_W-1:0];
                    end
                end
                lir_pkg::OP_FIRST: begin
                    prev_next      = cur_reg;
                    have_prev_next = 1'b1;
                end
                lir_pkg::OP_MUL_SPAN: begin
                    prod_next = lir_pkg::PROD_W'(frac_s * diff);
                    s1_next   = prev_reg;
                end
                lir_pkg::OP_MUL_TAIL: begin
                    prod_next = '0;
                    s1_next   = cur_reg;
                end
                lir_pkg::OP_ABS: begin
                    neg_next = span_v[lir_pkg::PROD_W-1];
                    abs_next = lir_pkg::ABS_W'(span_v[lir_pkg::PROD_W-1] ? -span_v : span_v);
                end
                lir_pkg::OP_EMIT: begin
                    push            = pend_valid_reg;
                    pend_next       = result;
                    pend_valid_next = 1'b1;
                    pos_next        = pos_adv;
                end
                lir_pkg::OP_WRAP: begin
                    pos_next = {2'b00, pos_reg[lir_pkg::FRAC_W-1:0]};
                end
                lir_pkg::OP_FLUSH: begin
                    push            = pend_valid_reg;
                    pend_valid_next = 1'b0;
                    prev_next       = cur_reg;
                end
                lir_pkg::OP_FINISH: begin
                    push            = pend_valid_reg;
                    push_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    prev_next       = '0;
                    have_prev_next  = 1'b0;
                    pos_next        = '0;
                end
                default: begin
                end
            endcase
        end

        if (push) begin
            m_valid_next          = 1'b1;
            m_data_next.sample_out = $signed(pend_reg);
            m_data_next.last_out   = push_last;
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
            m_data_next  = m_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg     <= lir_pkg::PERIOD_RESET;
            upc_reg        <= lir_pkg::U_FETCH;
            have_prev_reg  <= 1'b0;
            pos_reg        <= '0;
            prev_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            period_reg     <= period_next;
            upc_reg        <= upc_next;
            have_prev_reg  <= have_prev_next;
            pos_reg        <= pos_next;
            prev_reg       <= prev_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        step_reg   <= step_next;
        cur_reg    <= cur_next;
        last_reg   <= last_next;
        den_reg    <= den_next;
        dq_reg     <= dq_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        prod_reg   <= prod_next;
        s1_reg     <= s1_next;
        abs_reg    <= abs_next;
        neg_reg    <= neg_next;
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
    end

endmodule

### src/lir_checker.sv
// Port-level checker for the resampler and the bind that attaches it to the top level.
// Depends on lir_pkg for the payload types.
`timescale 1ns / 1ps

module lir_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic [lir_pkg::ADDR_W-1:0] paddr,
    input logic [31:0]                pwdata,
    input logic [31:0]                prdata,
    input logic                       pready,
    input logic                       s_valid,
    input logic                       s_ready,
    input lir_pkg::lir_in_t           s_data,
    input logic                       m_valid,
    input logic                       m_ready,
    input lir_pkg::lir_out_t          m_data
);

    // A waiting input transfer keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input changed while waiting");

    // A stalled result transfer keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Interpolation is symmetric in magnitude, so the most negative code never appears.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.sample_out != 16'sh8000)
        else $error("result out of range");

    // The period register reads back with its unused upper bits clear.
    assert property (@(posedge aclk) disable iff (!aresetn)
        psel && !pwrite && paddr[2] == lir_pkg::REG_IDX_PERIOD |-> prdata[31:11] == 21'd0)
        else $error("period readback has stray bits");

    // A period write is visible on the very next read.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && pready && paddr[2] == lir_pkg::REG_IDX_PERIOD)
        ##1 (psel && !pwrite && paddr[2] == lir_pkg::REG_IDX_PERIOD)
        |-> prdata[10:0] == $past(pwdata[10:0]))
        else $error("period readback does not match the write");

endmodule

bind linear_interp_audio_resampler lir_checker u_lir_checker (.*);
